FILE: src/vca_pkg.sv
// shared constants, codes and types of the voice channel allocator
// no dependencies; used by every module of the block
package vca_pkg;

    localparam int VOICE_SLOTS      = 64;
    localparam int FIRST_SLOT_INDEX = 4;

    localparam int SLOT_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);

    localparam int OP_W     = 2;
    localparam int OWNER_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int LEN_W    = 24;
    localparam int TIME_W   = 30;
    localparam int IDX_W    = 9;
    localparam int VIEW_W   = 15;
    localparam int STATUS_W = 2;
    localparam int END_W    = 31;
    localparam int LIFE_W   = 32;

    localparam logic [LIFE_W-1:0] LIFE_START = 32'h7fff_ffff;
    localparam logic [CHAN_W-1:0] CHAN_ANY   = '1;
    localparam logic [CHAN_W-1:0] CHAN_FREE  = '0;

    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP_OWN = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP_IDX = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP_ALL = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    typedef struct packed {
        logic               busy;
        logic [OWNER_W-1:0] owner;
        logic [CHAN_W-1:0]  chan;
        logic               loops;
        logic [END_W-1:0]   end_time;
    } slot_entry_t;

    typedef struct packed {
        logic clear;
        logic eval;
        logic start_mode;
    } scan_ctl_t;

    typedef struct packed {
        logic              hit;
        logic              found;
        logic [SLOT_W-1:0] pick;
    } scan_res_t;

endpackage

FILE: src/vca_slot_mem.sv
// voice slot table: one write port, one registered read port
// entries never written since reset or clear-all read as zero; uses vca_pkg
module vca_slot_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear_all,
    input  logic                        rd_en,
    input  logic [vca_pkg::SLOT_W-1:0]  rd_addr,
    output vca_pkg::slot_entry_t        rd_data,
    input  logic                        wr_en,
    input  logic [vca_pkg::SLOT_W-1:0]  wr_addr,
    input  vca_pkg::slot_entry_t        wr_data
);

    vca_pkg::slot_entry_t                mem [vca_pkg::VOICE_SLOTS];
    vca_pkg::slot_entry_t                rd_q_reg;
    logic [vca_pkg::VOICE_SLOTS-1:0]     valid_reg;
    logic                                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits stand in for clearing the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

FILE: src/vca_scan_unit.sv
// shared compare unit: tests one slot per cycle for a key match and tracks
// the shortest remaining life seen so far; uses vca_pkg
module vca_scan_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vca_pkg::scan_ctl_t           ctl,
    input  logic [vca_pkg::OWNER_W-1:0]  req_owner,
    input  logic [vca_pkg::CHAN_W-1:0]   req_chan,
    input  logic [vca_pkg::TIME_W-1:0]   req_time,
    input  logic [vca_pkg::VIEW_W-1:0]   viewer,
    input  vca_pkg::slot_entry_t         entry,
    input  logic [vca_pkg::SLOT_W-1:0]   slot,
    output vca_pkg::scan_res_t           res
);

    logic signed [vca_pkg::LIFE_W-1:0]  best_reg;
    logic signed [vca_pkg::LIFE_W-1:0]  best_next;
    logic signed [vca_pkg::LIFE_W-1:0]  life;
    logic                               found_reg;
    logic                               found_next;
    logic [vca_pkg::SLOT_W-1:0]         pick_reg;
    logic [vca_pkg::SLOT_W-1:0]         pick_next;
    logic [vca_pkg::OWNER_W-1:0]        view_owner;
    logic                               own_match;
    logic                               key_hit;
    logic                               skip;
    logic                               better;

    always_comb
    begin
        view_owner = {1'b0, viewer};
        own_match  = (entry.owner == req_owner);
        if (!ctl.start_mode)
        begin
            key_hit = own_match && (entry.chan == req_chan);
        end
        else if (req_chan != vca_pkg::CHAN_FREE)
        begin
            key_hit = own_match && ((entry.chan == req_chan) || (req_chan == vca_pkg::CHAN_ANY));
        end
        else
        begin
            key_hit = !entry.busy;
        end

        // busy looped voices are protected, and so are the viewer's busy voices unless the viewer itself asks
        skip = entry.busy && (entry.loops ||
               ((entry.owner == view_owner) && (req_owner != view_owner)));
        life = $signed(vca_pkg::LIFE_W'({1'b0, entry.end_time}) -
                       vca_pkg::LIFE_W'({2'b00, req_time}));
        better = ctl.eval && ctl.start_mode && !skip && (life < best_reg);

        res.hit   = ctl.eval && key_hit;
        res.found = found_reg || better;
        res.pick  = better ? slot : pick_reg;

        best_next  = best_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        if (ctl.clear)
        begin
            best_next  = $signed(vca_pkg::LIFE_START);
            found_next = 1'b0;
            pick_next  = '0;
        end
        else if (better)
        begin
            best_next  = life;
            found_next = 1'b1;
            pick_next  = slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= $signed(vca_pkg::LIFE_START);
            found_reg <= 1'b0;
            pick_reg  <= '0;
        end
        else
        begin
            best_reg  <= best_next;
            found_reg <= found_next;
            pick_reg  <= pick_next;
        end
    end

endmodule

FILE: src/voice_channel_allocator_unit.sv
// top level of the voice channel allocator: sequencer, handshakes, output register
// depends on vca_pkg, vca_slot_mem and vca_scan_unit
//
// Keeps a table of VOICE_SLOTS voice slots (absolute channel index
// FIRST_SLOT_INDEX + slot) and serves one transaction at a time; in_stall is
// high from acceptance until the result has been handed to the output
// register. A start or stop-by-owner transaction walks the slot table through
// the single read port of the slot memory, one slot per cycle, with the scan
// unit comparing each slot as its data returns: a scan runs to the end of the
// table unless it stops early on a direct match. Stop by index reads the slot,
// writes it and then reaches the result state; stop all and out-of-range
// indices go straight to the result state. After reset the table is empty at
// once; no clearing pass is needed. The output register
// lets the next transaction be accepted while a result still waits under
// out_stall. viewer_entity is written through cfg_wr_en / cfg_wr_data and
// should only change while the block is idle.
module voice_channel_allocator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [vca_pkg::VIEW_W-1:0]           cfg_wr_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vca_pkg::OP_W-1:0]             opcode,
    input  logic signed [vca_pkg::OWNER_W-1:0]   owner_entity,
    input  logic signed [vca_pkg::CHAN_W-1:0]    owner_channel,
    input  logic [vca_pkg::LEN_W-1:0]            sound_length,
    input  logic                                 sound_looped,
    input  logic [vca_pkg::TIME_W-1:0]           current_time,
    input  logic [vca_pkg::IDX_W-1:0]            slot_index,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vca_pkg::STATUS_W-1:0]         status,
    output logic [vca_pkg::IDX_W-1:0]            chosen_index
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [vca_pkg::CNT_W-1:0]        ptr_reg, ptr_next;
    logic [vca_pkg::SLOT_W-1:0]       eptr_reg, eptr_next;
    logic                             rdv_reg, rdv_next;
    logic [vca_pkg::SLOT_W-1:0]       pick_slot_reg, pick_slot_next;
    logic [vca_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [vca_pkg::IDX_W-1:0]        res_index_reg, res_index_next;
    logic                             out_valid_reg, out_valid_next;
    logic [vca_pkg::STATUS_W-1:0]     status_reg;
    logic [vca_pkg::IDX_W-1:0]        chosen_reg;
    logic [vca_pkg::VIEW_W-1:0]       viewer_reg;

    // captured request
    logic [vca_pkg::OP_W-1:0]         req_op_reg;
    logic [vca_pkg::OWNER_W-1:0]      req_owner_reg;
    logic [vca_pkg::CHAN_W-1:0]       req_chan_reg;
    logic [vca_pkg::LEN_W-1:0]        req_len_reg;
    logic                             req_loop_reg;
    logic [vca_pkg::TIME_W-1:0]       req_time_reg;

    logic                             accept;
    logic                             idx_in_range;
    logic [vca_pkg::SLOT_W-1:0]       idx_slot;
    logic                             issue;
    logic                             eval;
    logic                             scan_end;
    logic                             out_load;
    logic                             clear_all;
    logic [vca_pkg::SLOT_W-1:0]       rd_addr;
    logic                             wr_en;
    vca_pkg::slot_entry_t             rd_data;
    vca_pkg::slot_entry_t             wr_data;
    vca_pkg::scan_ctl_t               scan_ctl;
    vca_pkg::scan_res_t               scan_res;

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign clear_all    = accept && (opcode == vca_pkg::OP_STOP_ALL);
    assign idx_in_range = (slot_index >= vca_pkg::IDX_W'(vca_pkg::FIRST_SLOT_INDEX)) &&
                          (slot_index < vca_pkg::IDX_W'(vca_pkg::FIRST_SLOT_INDEX +
                                                        vca_pkg::VOICE_SLOTS));
    assign idx_slot     = vca_pkg::SLOT_W'(slot_index - vca_pkg::IDX_W'(vca_pkg::FIRST_SLOT_INDEX));

    // one slot read per cycle while scanning; the data comes back in the cycle after
    assign eval     = (state_reg == S_SCAN) && rdv_reg;
    assign scan_end = eval && (ptr_reg == vca_pkg::CNT_W'(vca_pkg::VOICE_SLOTS));
    assign issue    = ((state_reg == S_SCAN) &&
                       (ptr_reg < vca_pkg::CNT_W'(vca_pkg::VOICE_SLOTS)) &&
                       !(eval && scan_res.hit)) ||
                      (state_reg == S_FETCH);
    assign rd_addr  = (state_reg == S_FETCH) ? pick_slot_reg : ptr_reg[vca_pkg::SLOT_W-1:0];
    assign wr_en    = (state_reg == S_WRITE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign scan_ctl.clear      = accept;
    assign scan_ctl.eval       = eval;
    assign scan_ctl.start_mode = (req_op_reg == vca_pkg::OP_START);

    vca_slot_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .rd_en     (issue),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (pick_slot_reg),
        .wr_data   (wr_data)
    );

    vca_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .req_owner (req_owner_reg),
        .req_chan  (req_chan_reg),
        .req_time  (req_time_reg),
        .viewer    (viewer_reg),
        .entry     (rd_data),
        .slot      (eptr_reg),
        .res       (scan_res)
    );

    // new slot contents; a stopped slot keeps owner and channel
    always_comb
    begin
        wr_data = '0;
        case (req_op_reg)
            vca_pkg::OP_START:
            begin
                wr_data.busy     = 1'b1;
                wr_data.owner    = req_owner_reg;
                wr_data.chan     = req_chan_reg;
                wr_data.loops    = req_loop_reg;
                wr_data.end_time = vca_pkg::END_W'({1'b0, req_time_reg}) +
                                   vca_pkg::END_W'(req_len_reg);
            end
            vca_pkg::OP_STOP_OWN:
            begin
                wr_data.owner = req_owner_reg;
                wr_data.chan  = req_chan_reg;
            end
            vca_pkg::OP_STOP_IDX:
            begin
                wr_data.owner = rd_data.owner;
                wr_data.chan  = rd_data.chan;
            end
            default:
            begin
                wr_data = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pick_slot_next  = pick_slot_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        rdv_next        = issue && (state_reg == S_SCAN);
        eptr_next       = ptr_reg[vca_pkg::SLOT_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next        = '0;
                    res_status_next = vca_pkg::STATUS_DONE;
                    res_index_next  = '0;
                    unique case (opcode)
                        vca_pkg::OP_START, vca_pkg::OP_STOP_OWN:
                        begin
                            state_next = S_SCAN;
                        end
                        vca_pkg::OP_STOP_IDX:
                        begin
                            if (idx_in_range)
                            begin
                                pick_slot_next = idx_slot;
                                state_next     = S_FETCH;
                            end
                            else
                            begin
                                res_status_next = vca_pkg::STATUS_NO_MATCH;
                                state_next      = S_DONE;
                            end
                        end
                        vca_pkg::OP_STOP_ALL:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                priority if (eval && scan_res.hit)
                begin
                    pick_slot_next = eptr_reg;
                    state_next     = S_WRITE;
                end
                else if (scan_end)
                begin
                    if (scan_ctl.start_mode && scan_res.found)
                    begin
                        pick_slot_next = scan_res.pick;
                        state_next     = S_WRITE;
                    end
                    else
                    begin
                        res_status_next = scan_ctl.start_mode ? vca_pkg::STATUS_NO_SLOT
                                                              : vca_pkg::STATUS_NO_MATCH;
                        res_index_next  = '0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_FETCH:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                res_status_next = vca_pkg::STATUS_DONE;
                res_index_next  = vca_pkg::IDX_W'(vca_pkg::FIRST_SLOT_INDEX) +
                                  vca_pkg::IDX_W'(pick_slot_reg);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            viewer_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                viewer_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eptr_reg       <= eptr_next;
        pick_slot_reg  <= pick_slot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (accept)
        begin
            req_op_reg    <= opcode;
            req_owner_reg <= owner_entity;
            req_chan_reg  <= owner_channel;
            req_len_reg   <= sound_length;
            req_loop_reg  <= sound_looped;
            req_time_reg  <= current_time;
        end
        if (out_load)
        begin
            status_reg <= res_status_reg;
            chosen_reg <= res_index_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_reg;

    // a failed transaction never reports a channel index
    a_fail_no_index : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != vca_pkg::STATUS_DONE)) |-> (chosen_index == '0))
        else $error("failed transaction carries a channel index");

    // a new result is only loaded from the completion state
    a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside completion state");

    // stop all finishes without touching the scan path
    a_stop_all_direct : assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> (state_reg == S_DONE))
        else $error("stop all did not go straight to completion");

    // the scan pointer never runs past the table
    a_ptr_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (ptr_reg <= vca_pkg::CNT_W'(vca_pkg::VOICE_SLOTS)))
        else $error("scan pointer out of range");

endmodule
